// File: rtl/core/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types, codes and constant tables of the aspect-ratio classifier.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int RATIO_W         = 16;
  localparam int LOG_W           = 16;
  localparam int GAP_W           = LOG_W + 1;
  localparam int RATIO_FRAC_BITS = 13;
  localparam int LOG_FRAC_BITS   = 12;
  localparam int LOG_CNT_W       = $clog2(LOG_FRAC_BITS);
  localparam int TOL_W           = 13;
  localparam int COUNT_W         = 5;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 13;
  localparam int SLOT_W          = 4;
  localparam int BUILTIN_COUNT   = 16;

  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_NEAREST = 2'd1;
  localparam logic [1:0] MODE_MATCH   = 2'd2;
  localparam logic [1:0] MODE_RESOLVE = 2'd3;

  localparam logic [1:0] FILT_DETECT  = 2'd1;
  localparam logic [1:0] FILT_DECLARE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 1'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 13'd123;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [LOG_W-1:0]   lg;
    logic               det;
    logic               decl;
  } entry_t;

  // Log2 of a ratio, evaluated at elaboration for the built-in table.
  function automatic logic [LOG_W-1:0] log2_const(input logic [RATIO_W-1:0] x);
    int p;
    int i;
    int frac;
    int v;
    logic [31:0] m;
    p = 0;
    for (i = 0; i < RATIO_W; i++) begin
      if (x[i]) p = i;
    end
    m = 32'(x) << (15 - p);
    frac = 0;
    for (i = 0; i < LOG_FRAC_BITS; i++) begin
      m = (m * m) >> 15;
      frac = frac * 2;
      if (m >= 32'd65536) begin
        m = m >> 1;
        frac = frac + 1;
      end
    end
    v = (p - RATIO_FRAC_BITS) * (1 << LOG_FRAC_BITS) + frac;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return LOG_W'(v);
  endfunction

  localparam logic [RATIO_W-1:0] BUILTIN_RATIO [BUILTIN_COUNT] = '{
    16'd8192,  16'd9748,  16'd10923, 16'd11223, 16'd11715, 16'd12288, 16'd13599, 16'd14564,
    16'd15155, 16'd15565, 16'd16384, 16'd18022, 16'd19251, 16'd19661, 16'd20890, 16'd22610};

  localparam logic [LOG_W-1:0] BUILTIN_LOG [BUILTIN_COUNT] = '{
    log2_const(16'd8192),  log2_const(16'd9748),  log2_const(16'd10923),
    log2_const(16'd11223), log2_const(16'd11715), log2_const(16'd12288),
    log2_const(16'd13599), log2_const(16'd14564), log2_const(16'd15155),
    log2_const(16'd15565), log2_const(16'd16384), log2_const(16'd18022),
    log2_const(16'd19251), log2_const(16'd19661), log2_const(16'd20890),
    log2_const(16'd22610)};

  localparam logic [BUILTIN_COUNT-1:0] BUILTIN_DETECT = 16'h3FDE;

  function automatic entry_t reset_entry(input logic [31:0] idx);
    entry_t e;
    e = '0;
    if (idx < 32'(BUILTIN_COUNT)) begin
      e.ratio = BUILTIN_RATIO[idx[3:0]];
      e.lg    = BUILTIN_LOG[idx[3:0]];
      e.det   = BUILTIN_DETECT[idx[3:0]];
      e.decl  = 1'b1;
    end
    return e;
  endfunction

  function automatic logic [GAP_W-1:0] log_gap(input logic [LOG_W-1:0] a,
                                               input logic [LOG_W-1:0] b);
    logic signed [GAP_W-1:0] d;
    d = $signed({a[LOG_W-1], a}) - $signed({b[LOG_W-1], b});
    return d[GAP_W-1] ? GAP_W'(-d) : GAP_W'(d);
  endfunction

endpackage

// File: rtl/core/arc_log2.sv
// ----------------------------------------------------------------------------
// arc_log2
// Iterative log2 unit: leading-one normalization, then one squaring per cycle.
// ----------------------------------------------------------------------------
module arc_log2 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [arc_pkg::RATIO_W-1:0] x,
  output logic                        busy,
  output logic [arc_pkg::LOG_W-1:0]   result
);

  localparam int LFB = arc_pkg::LOG_FRAC_BITS;

  logic                          busy_r;
  logic [arc_pkg::LOG_CNT_W-1:0] cnt_r;
  logic [15:0]                   m_r;
  logic [3:0]                    p_r;
  logic [LFB-1:0]                frac_r;
  logic [arc_pkg::LOG_W-1:0]     res_r;

  logic [3:0]     p_in;
  logic [15:0]    m_in;
  logic [31:0]    sqr;
  logic [16:0]    mq;
  logic [15:0]    m_nxt;
  logic [LFB-1:0] frac_nxt;
  logic           last;
  int             v;

  always_comb begin
    p_in = '0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) p_in = 4'(i);
    end
    m_in     = x << (4'd15 - p_in);
    sqr      = 32'(m_r) * 32'(m_r);
    mq       = sqr[31:15];
    m_nxt    = mq[16] ? mq[16:1] : mq[15:0];
    frac_nxt = {frac_r[LFB-2:0], mq[16]};
    last     = cnt_r == arc_pkg::LOG_CNT_W'(LFB - 1);
    v = (int'(p_r) - arc_pkg::RATIO_FRAC_BITS) * (1 << LFB) + int'(frac_nxt);
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r    <= m_in;
      p_r    <= p_in;
      frac_r <= '0;
    end else if (busy_r) begin
      m_r    <= m_nxt;
      frac_r <= frac_nxt;
      if (last) res_r <= arc_pkg::LOG_W'(v);
    end
  end

  assign busy   = busy_r;
  assign result = res_r;

endmodule

// File: rtl/core/arc_table.sv
// ----------------------------------------------------------------------------
// arc_table
// Entry memory with registered read. Slots never written since reset
// read back as the built-in entry.
// ----------------------------------------------------------------------------
module arc_table #(
  parameter int ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  arc_pkg::entry_t       wr_data,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output arc_pkg::entry_t       rd_data
);

  localparam int AW = $clog2(ENTRIES);

  arc_pkg::entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] written_r;
  arc_pkg::entry_t    rd_q_r;
  logic               rd_written_r;
  logic [AW-1:0]      rd_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (wr_en) begin
      written_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q_r       <= mem[rd_addr];
    rd_written_r <= written_r[rd_addr];
    rd_addr_r    <= rd_addr;
  end

  assign rd_data = rd_written_r ? rd_q_r : arc_pkg::reset_entry(32'(rd_addr_r));

endmodule

// File: rtl/core/aspect_ratio_classifier_core.sv
// ----------------------------------------------------------------------------
// aspect_ratio_classifier_core
// Classifies a ratio against a table of aspect-ratio entries.
// ----------------------------------------------------------------------------
// One item is handled at a time. A write, or a query of ratio zero, waits for
// the twelve squaring steps of the log2 unit, then goes to the output register.
// A query takes the log2 step first, then a scan over the N entries in use
// that reads one table entry per cycle from the entry memory. A finished
// result waits in the output register while the next item is taken; a
// stalled output holds the next result back until it leaves.
module aspect_ratio_classifier_core #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [15:0]                    in_ratio,
  input  logic [15:0]                    in_toward_ratio,
  input  logic [1:0]                     in_use_filter,
  input  logic [3:0]                     in_entry_slot,
  input  logic                           in_entry_detect,
  input  logic                           in_entry_declare,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_found,
  output logic [3:0]                     out_entry_index,
  output logic [15:0]                    out_entry_ratio,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int GW = arc_pkg::GAP_W;

  typedef enum logic [1:0] {S_IDLE, S_LOG, S_SCAN, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_found_r, out_found_nxt;
  logic [3:0]  out_idx_r, out_idx_nxt;
  logic [15:0] out_ratio_r, out_ratio_nxt;
  logic [arc_pkg::COUNT_W-1:0] ent_cnt_r;
  logic [arc_pkg::TOL_W-1:0]   tol_r;
  logic   pend_r, pend_nxt;

  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] ratio_r, ratio_nxt;
  logic [15:0] toward_r, toward_nxt;
  logic [1:0]  filt_r, filt_nxt;
  logic [3:0]  slot_r, slot_nxt;
  logic        det_r, det_nxt;
  logic        decl_r, decl_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          pk_v_r, pk_v_nxt;
  logic [AW-1:0] pk_slot_r, pk_slot_nxt;
  logic [15:0]   pk_ratio_r, pk_ratio_nxt;
  logic [arc_pkg::LOG_W-1:0] pk_log_r, pk_log_nxt;
  logic          done_r, done_nxt;
  logic [GW-1:0] boff_r, boff_nxt;
  logic [GW-1:0] bpull_r, bpull_nxt;
  logic          res_found_r, res_found_nxt;
  logic [3:0]    res_idx_r, res_idx_nxt;
  logic [15:0]   res_ratio_r, res_ratio_nxt;

  logic in_acc;
  logic busy_a, busy_b;
  logic [arc_pkg::LOG_W-1:0] log_a, log_b;
  logic            wr_en;
  arc_pkg::entry_t wr_data;
  arc_pkg::entry_t rd;
  logic [CW-1:0]   n_act;
  logic            pass;
  logic [31:0]     prod;
  logic [GW-1:0]   off, pull, match_gap;
  logic [31:0]     pk_slot_w;
  logic            ok_wr, found;

  arc_log2 u_log_a (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .x(in_ratio),
    .busy(busy_a), .result(log_a)
  );

  arc_log2 u_log_b (
    .clk(clk), .rst_n(rst_n), .start(in_acc), .x(in_toward_ratio),
    .busy(busy_b), .result(log_b)
  );

  arc_table #(.ENTRIES(ENTRIES)) u_table (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(AW'(32'(slot_r))),
    .wr_data(wr_data), .rd_addr(iss_r[AW-1:0]), .rd_data(rd)
  );

  assign in_stall  = state_r != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    n_act = (32'(ent_cnt_r) > 32'(ENTRIES)) ? CW'(ENTRIES) : CW'(ent_cnt_r);
    if (filt_r == arc_pkg::FILT_DETECT) pass = rd.det;
    else if (filt_r == arc_pkg::FILT_DECLARE) pass = rd.decl;
    else pass = 1'b1;
    prod      = 32'(pk_ratio_r) * 32'(rd.ratio);
    off       = arc_pkg::log_gap(log_a, rd.lg);
    pull      = (toward_r != '0) ? arc_pkg::log_gap(log_b, rd.lg) : '1;
    match_gap = arc_pkg::log_gap(log_a, pk_log_r);
    pk_slot_w = 32'(pk_slot_r);
    ok_wr     = (ratio_r != '0) && (32'(slot_r) < 32'(ENTRIES));
    found     = (mode_r == arc_pkg::MODE_MATCH)
                ? (pk_v_r && match_gap <= GW'(tol_r)) : pk_v_r;
    wr_data   = '{ratio: ratio_r, lg: log_a, det: det_r, decl: decl_r};
    wr_en     = 1'b0;

    state_nxt = state_r;   out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r; out_idx_nxt = out_idx_r; out_ratio_nxt = out_ratio_r;
    pend_nxt = 1'b0;       mode_nxt = mode_r;     ratio_nxt = ratio_r;
    toward_nxt = toward_r; filt_nxt = filt_r;     slot_nxt = slot_r;
    det_nxt = det_r;       decl_nxt = decl_r;     sq_nxt = sq_r;
    iss_nxt = iss_r;       pidx_nxt = pidx_r;     pk_v_nxt = pk_v_r;
    pk_slot_nxt = pk_slot_r; pk_ratio_nxt = pk_ratio_r; pk_log_nxt = pk_log_r;
    done_nxt = done_r;     boff_nxt = boff_r;     bpull_nxt = bpull_r;
    res_found_nxt = res_found_r; res_idx_nxt = res_idx_r; res_ratio_nxt = res_ratio_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_mode;
          ratio_nxt  = in_ratio;
          toward_nxt = in_toward_ratio;
          filt_nxt   = in_use_filter;
          slot_nxt   = in_entry_slot;
          det_nxt    = in_entry_detect;
          decl_nxt   = in_entry_declare;
          sq_nxt     = 32'(in_ratio) * 32'(in_ratio);
          state_nxt  = S_LOG;
        end
      end
      S_LOG: begin
        if (!busy_a && !busy_b) begin
          iss_nxt  = '0;
          pk_v_nxt = 1'b0;
          done_nxt = 1'b0;
          if (mode_r == arc_pkg::MODE_WRITE) begin
            wr_en         = ok_wr;
            res_found_nxt = ok_wr;
            res_idx_nxt   = ok_wr ? slot_r : '0;
            res_ratio_nxt = ok_wr ? ratio_r : '0;
            state_nxt     = S_FIN;
          end else if (ratio_r == '0) begin
            res_found_nxt = 1'b0;
            res_idx_nxt   = '0;
            res_ratio_nxt = '0;
            state_nxt     = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (iss_r != n_act) begin
          pend_nxt = 1'b1;
          pidx_nxt = iss_r[AW-1:0];
          iss_nxt  = iss_r + 1'b1;
        end
        if (pend_r && pass) begin
          if (mode_r != arc_pkg::MODE_RESOLVE) begin
            if (!done_r) begin
              if (pk_v_r && sq_r < prod) begin
                done_nxt = 1'b1;
              end else begin
                pk_v_nxt = 1'b1; pk_slot_nxt = pidx_r;
                pk_ratio_nxt = rd.ratio; pk_log_nxt = rd.lg;
              end
            end
          end else if (off <= GW'(tol_r) &&
                       (!pk_v_r || pull < bpull_r || (pull == bpull_r && off < boff_r))) begin
            pk_v_nxt = 1'b1; pk_slot_nxt = pidx_r;
            pk_ratio_nxt = rd.ratio; pk_log_nxt = rd.lg;
            boff_nxt = off; bpull_nxt = pull;
          end
        end
        if (iss_r == n_act && !pend_r) begin
          res_found_nxt = found;
          res_idx_nxt   = found ? pk_slot_w[3:0] : '0;
          res_ratio_nxt = found ? pk_ratio_r : '0;
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          out_ratio_nxt = res_ratio_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
      out_idx_r   <= '0;
      out_ratio_r <= '0;
      pend_r      <= 1'b0;
      ent_cnt_r   <= arc_pkg::COUNT_RESET;
      tol_r       <= arc_pkg::TOL_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
      out_idx_r   <= out_idx_nxt;
      out_ratio_r <= out_ratio_nxt;
      pend_r      <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          arc_pkg::CFG_ENTRY_COUNT: ent_cnt_r <= cfg_wdata[arc_pkg::COUNT_W-1:0];
          arc_pkg::CFG_TOLERANCE:   tol_r     <= cfg_wdata[arc_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;       ratio_r <= ratio_nxt;     toward_r <= toward_nxt;
    filt_r <= filt_nxt;       slot_r <= slot_nxt;       det_r <= det_nxt;
    decl_r <= decl_nxt;       sq_r <= sq_nxt;           iss_r <= iss_nxt;
    pidx_r <= pidx_nxt;       pk_v_r <= pk_v_nxt;       pk_slot_r <= pk_slot_nxt;
    pk_ratio_r <= pk_ratio_nxt; pk_log_r <= pk_log_nxt; done_r <= done_nxt;
    boff_r <= boff_nxt;       bpull_r <= bpull_nxt;     res_found_r <= res_found_nxt;
    res_idx_r <= res_idx_nxt; res_ratio_r <= res_ratio_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_entry_index = out_idx_r;
  assign out_entry_ratio = out_ratio_r;

endmodule

// File: sim/aspect_ratio_classifier_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspect_ratio_classifier_core_tb
// Self-checking testbench of the aspect-ratio classifier. Items go in with
// random gaps, results are taken with random stalls, and every result is
// compared against a behavioral model of the entry table and its queries.
// ----------------------------------------------------------------------------
module aspect_ratio_classifier_core_tb;

  localparam logic [1:0] FILT_ANY   = 2'd0;
  localparam logic [1:0] FILT_OTHER = 2'd3;
  localparam int SLOTS = 16;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic        found;
    logic [3:0]  index;
    logic [15:0] ratio;
  } answer_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_mode = arc_pkg::MODE_NEAREST;
  logic [15:0]                    in_ratio = '0;
  logic [15:0]                    in_toward_ratio = '0;
  logic [1:0]                     in_use_filter = FILT_ANY;
  logic [3:0]                     in_entry_slot = '0;
  logic                           in_entry_detect = 1'b0;
  logic                           in_entry_declare = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_found;
  logic [3:0]                     out_entry_index;
  logic [15:0]                    out_entry_ratio;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [arc_pkg::CFG_IDX_W-1:0]  cfg_index = arc_pkg::CFG_ENTRY_COUNT;
  logic [arc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [15:0] tbl_ratio [SLOTS];
  int          tbl_log [SLOTS];
  bit          tbl_det [SLOTS];
  bit          tbl_decl [SLOTS];
  int unsigned used_count;
  int unsigned tolerance;

  answer_t answers_due [$];
  int      fail_count = 0;
  int      mode_count [4] = '{0, 0, 0, 0};
  int      found_count = 0;
  int      idle_cycles = 0;
  bit      no_gaps = 1'b0;
  int      stall_hold = 0;
  bit      stall_now = 1'b0;

  aspect_ratio_classifier_core i_dut (.*);

  always #2 clk = ~clk;

  function automatic int ratio_log2(logic [15:0] x);
    int p;
    int frac;
    int v;
    longint unsigned m;
    if (x == 0) return -8 * 4096;
    p = 15;
    while (p > 0 && !x[p]) p--;
    m = longint'(x) << (15 - p);
    frac = 0;
    for (int i = 0; i < arc_pkg::LOG_FRAC_BITS; i++) begin
      m = (m * m) >> 15;
      frac = frac * 2;
      if (m >= 65536) begin
        m = m >> 1;
        frac = frac + 1;
      end
    end
    v = (p - arc_pkg::RATIO_FRAC_BITS) * 4096 + frac;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  function automatic int unsigned log_distance(int a, int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic bit usable(int s, logic [1:0] filt);
    if (filt == arc_pkg::FILT_DETECT) return tbl_det[s];
    if (filt == arc_pkg::FILT_DECLARE) return tbl_decl[s];
    return 1'b1;
  endfunction

  function automatic int nearest_entry(logic [15:0] r, logic [1:0] filt);
    longint unsigned sq;
    int prev;
    int n;
    sq = longint'(r) * longint'(r);
    prev = -1;
    n = (used_count > SLOTS) ? SLOTS : used_count;
    if (r == 0) return -1;
    for (int i = 0; i < n; i++) begin
      if (!usable(i, filt)) continue;
      if (prev >= 0 && sq < longint'(tbl_ratio[prev]) * longint'(tbl_ratio[i])) return prev;
      prev = i;
    end
    return prev;
  endfunction

  function automatic int resolved_entry(logic [15:0] r, logic [1:0] filt, logic [15:0] tw);
    int wanted;
    int rest;
    int chosen;
    int n;
    longint unsigned off;
    longint unsigned pull;
    longint unsigned best_off;
    longint unsigned best_pull;
    chosen = -1;
    best_off = 0;
    best_pull = 0;
    n = (used_count > SLOTS) ? SLOTS : used_count;
    if (r == 0) return -1;
    wanted = ratio_log2(r);
    rest = ratio_log2(tw);
    for (int i = 0; i < n; i++) begin
      if (!usable(i, filt)) continue;
      off = log_distance(wanted, tbl_log[i]);
      if (off > tolerance) continue;
      pull = (tw != 0) ? log_distance(rest, tbl_log[i]) : 64'hFFFF_FFFF;
      if (chosen < 0 || pull < best_pull || (pull == best_pull && off < best_off)) begin
        chosen = i;
        best_off = off;
        best_pull = pull;
      end
    end
    return chosen;
  endfunction

  function automatic answer_t classify(logic [1:0] md, logic [15:0] r, logic [15:0] tw,
                                       logic [1:0] filt, logic [3:0] slot, bit det,
                                       bit decl);
    answer_t a;
    int pick;
    a = '0;
    pick = -1;
    if (md == arc_pkg::MODE_WRITE) begin
      if (r != 0) begin
        tbl_ratio[slot] = r;
        tbl_log[slot] = ratio_log2(r);
        tbl_det[slot] = det;
        tbl_decl[slot] = decl;
        a = '{1'b1, slot, r};
      end
      return a;
    end
    if (md == arc_pkg::MODE_NEAREST) begin
      pick = nearest_entry(r, filt);
    end else if (md == arc_pkg::MODE_MATCH) begin
      pick = nearest_entry(r, filt);
      if (pick >= 0 && log_distance(ratio_log2(r), tbl_log[pick]) > tolerance) pick = -1;
    end else begin
      pick = resolved_entry(r, filt, tw);
    end
    if (pick >= 0) a = '{1'b1, 4'(pick), tbl_ratio[pick]};
    return a;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (no_gaps || k < 55) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_hold == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        stall_now <= 1'b0;
        stall_hold <= $urandom_range(20, 80);
      end else begin
        stall_now <= $urandom_range(0, 1);
        stall_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      end
    end else begin
      stall_hold <= stall_hold - 1;
    end
    out_stall <= stall_now;
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_due.size() == 0) begin
        $error("Result transfer with no result due");
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          fail_count++;
        end
        if (out_entry_index !== want.index) begin
          $error("entry_index: expected %0d, got %0d", want.index, out_entry_index);
          fail_count++;
        end
        if (out_entry_ratio !== want.ratio) begin
          $error("entry_ratio: expected %0d, got %0d", want.ratio, out_entry_ratio);
          fail_count++;
        end
        if (want.found) found_count++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] md, logic [15:0] r, logic [15:0] tw, logic [1:0] filt,
                           logic [3:0] slot, bit det, bit decl);
    int gap;
    bit stalled;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= md;
    in_ratio <= r;
    in_toward_ratio <= tw;
    in_use_filter <= filt;
    in_entry_slot <= slot;
    in_entry_detect <= det;
    in_entry_declare <= decl;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    answers_due.push_back(classify(md, r, tw, filt, slot, det, decl));
    mode_count[md]++;
  endtask

  task automatic query(logic [1:0] md, logic [15:0] r, logic [15:0] tw, logic [1:0] filt);
    send_item(md, r, tw, filt, 4'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [arc_pkg::CFG_IDX_W-1:0] idx,
                           logic [arc_pkg::CFG_DATA_W-1:0] value);
    bit ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do begin
      @(negedge clk);
      ready_seen = cfg_ready;
      @(posedge clk);
    end while (!ready_seen);
    cfg_valid <= 1'b0;
    if (idx == arc_pkg::CFG_ENTRY_COUNT) used_count = value & 5'h1F;
    else tolerance = value;
  endtask

  task automatic test_builtin_table();
    for (int i = 0; i < SLOTS; i++) begin
      query(arc_pkg::MODE_NEAREST, arc_pkg::BUILTIN_RATIO[i], 16'd0, 2'(i % 4));
    end
    query(arc_pkg::MODE_MATCH, 16'd0, 16'd0, FILT_ANY);
    query(arc_pkg::MODE_MATCH, 16'd1, 16'd0, FILT_ANY);
    query(arc_pkg::MODE_MATCH, 16'hFFFF, 16'hFFFF, FILT_OTHER);
    query(arc_pkg::MODE_RESOLVE, 16'd14000, 16'd0, arc_pkg::FILT_DETECT);
    query(arc_pkg::MODE_RESOLVE, 16'd14000, 16'd8192, arc_pkg::FILT_DECLARE);
    query(arc_pkg::MODE_RESOLVE, 16'd1, 16'hFFFF, FILT_ANY);
    drain();
  endtask

  task automatic test_table_writes();
    send_item(arc_pkg::MODE_WRITE, 16'd0, 16'd0, FILT_ANY, 4'd3, 1'b1, 1'b1);
    drain();
    write_reg(arc_pkg::CFG_ENTRY_COUNT, 13'd4);
    write_reg(arc_pkg::CFG_TOLERANCE, 13'd5909);
    send_item(arc_pkg::MODE_WRITE, 16'hFFFF, 16'd0, FILT_ANY, 4'd15, 1'b1, 1'b0);
    send_item(arc_pkg::MODE_WRITE, 16'd5000, 16'd0, FILT_ANY, 4'd3, 1'b0, 1'b1);
    query(arc_pkg::MODE_NEAREST, 16'hFFFF, 16'd0, FILT_ANY);
    query(arc_pkg::MODE_MATCH, 16'd5000, 16'd0, arc_pkg::FILT_DETECT);
    query(arc_pkg::MODE_RESOLVE, 16'd9000, 16'd20000, arc_pkg::FILT_DECLARE);
    drain();
    write_reg(arc_pkg::CFG_ENTRY_COUNT, 13'd0);
    query(arc_pkg::MODE_NEAREST, 16'd9000, 16'd0, FILT_ANY);
    query(arc_pkg::MODE_RESOLVE, 16'd9000, 16'd0, FILT_ANY);
    drain();
    write_reg(arc_pkg::CFG_ENTRY_COUNT, 13'h1FFF);
    write_reg(arc_pkg::CFG_TOLERANCE, 13'd1);
    query(arc_pkg::MODE_MATCH, 16'hFFFF, 16'd0, FILT_ANY);
    query(arc_pkg::MODE_RESOLVE, 16'd12288, 16'd0, FILT_ANY);
    drain();
  endtask

  task automatic test_random_traffic();
    logic [15:0] r;
    logic [15:0] base;
    int k;
    for (int phase = 0; phase < 6; phase++) begin
      no_gaps = (phase == 2);
      case (phase)
        0: begin
          write_reg(arc_pkg::CFG_ENTRY_COUNT, 13'd16);
          write_reg(arc_pkg::CFG_TOLERANCE, 13'd123);
        end
        1: begin
          write_reg(arc_pkg::CFG_ENTRY_COUNT, 13'd1);
          write_reg(arc_pkg::CFG_TOLERANCE, 13'd5909);
        end
        2: begin
          write_reg(arc_pkg::CFG_ENTRY_COUNT, 13'($urandom_range(2, 15)));
          write_reg(arc_pkg::CFG_TOLERANCE, 13'($urandom_range(1, 600)));
        end
        default: begin
          write_reg(arc_pkg::CFG_ENTRY_COUNT, 13'($urandom_range(0, 31)));
          write_reg(arc_pkg::CFG_TOLERANCE, 13'($urandom));
        end
      endcase
      if (phase == 3) begin
        base = 16'($urandom_range(2000, 8000));
        for (int s = 0; s < SLOTS; s++) begin
          base = base + 16'($urandom_range(1, 2500));
          send_item(arc_pkg::MODE_WRITE, base, 16'd0, FILT_ANY, 4'(s), 1'($urandom),
                    1'($urandom));
        end
      end
      for (int n = 0; n < 220; n++) begin
        k = $urandom_range(0, 99);
        if (k < 70) r = 16'($urandom_range(7000, 24000));
        else if (k < 90) r = 16'($urandom);
        else r = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 9) == 0) begin
          send_item(arc_pkg::MODE_WRITE, r, 16'($urandom), 2'($urandom), 4'($urandom),
                    1'($urandom), 1'($urandom));
        end else begin
          query(2'($urandom_range(1, 3)), r,
                ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 1) ?
                  $urandom_range(7000, 24000) : $urandom),
                2'($urandom));
        end
      end
      drain();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tbl_ratio[i] = arc_pkg::BUILTIN_RATIO[i];
      tbl_log[i] = ratio_log2(arc_pkg::BUILTIN_RATIO[i]);
      tbl_det[i] = arc_pkg::BUILTIN_DETECT[i];
      tbl_decl[i] = 1'b1;
    end
    used_count = arc_pkg::COUNT_RESET;
    tolerance = arc_pkg::TOL_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_builtin_table();
    test_table_writes();
    test_random_traffic();
    $display("Covered %0d writes, %0d nearest, %0d match and %0d resolve transfers.",
             mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
    $display("%0d results reported a chosen or written entry.", found_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: aspect_ratio_classifier_core.f
rtl/core/arc_pkg.sv
rtl/core/arc_log2.sv
rtl/core/arc_table.sv
rtl/core/aspect_ratio_classifier_core.sv
sim/aspect_ratio_classifier_core_tb.sv
